[hw/rtl/ldrt_pkg.sv]
package ldrt_pkg;

	// Default table index width: one entry per symbol value.
	localparam int SYMBOL_BITS_DEF = 8;

	// Default width of the position counter and of each stored position.
	localparam int POSITION_BITS_DEF = 32;

	// Width of the length fields on the result channel.
	localparam int LEN_OUT_BITS = 9;

endpackage

[hw/rtl/ldrt_table.sv]
module ldrt_table #(
	parameter int SYMBOL_BITS   = ldrt_pkg::SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = ldrt_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [SYMBOL_BITS-1:0]   rd_addr,
	output logic                     rd_valid,
	output logic [POSITION_BITS-1:0] rd_pos,
	input  logic                     wr_en,
	input  logic [SYMBOL_BITS-1:0]   wr_addr,
	input  logic [POSITION_BITS-1:0] wr_pos,
	output logic                     clearing
);

	localparam int DEPTH     = 1 << SYMBOL_BITS;
	localparam int WORD_BITS = POSITION_BITS + 1;

	// Each word holds a valid flag above the stored position.
	logic [WORD_BITS-1:0]   mem [DEPTH];
	logic [WORD_BITS-1:0]   rd_word_q;
	logic                   clr_busy_q;
	logic [SYMBOL_BITS-1:0] clr_addr_q;

	// After reset, sweep the table once and clear every valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {SYMBOL_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= {1'b1, wr_pos};
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_valid = rd_word_q[WORD_BITS-1];
	assign rd_pos   = rd_word_q[POSITION_BITS-1:0];
	assign clearing = clr_busy_q;

endmodule

[hw/rtl/ldrt_update.sv]
module ldrt_update #(
	parameter int SYMBOL_BITS   = ldrt_pkg::SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = ldrt_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_sos,
	input  logic                             item_eos,
	input  logic [POSITION_BITS-1:0]         item_pos,
	input  logic                             entry_valid,
	input  logic [POSITION_BITS-1:0]         entry_pos,
	output logic                             commit,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ldrt_pkg::LEN_OUT_BITS-1:0] window_length,
	output logic [ldrt_pkg::LEN_OUT_BITS-1:0] best_length,
	output logic                             final_result
);

	localparam int OUT_BITS = ldrt_pkg::LEN_OUT_BITS;
	// A window of distinct symbols never exceeds the table depth.
	localparam int LEN_BITS = SYMBOL_BITS + 1;
	localparam int CMP_BITS = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;

	logic [LEN_BITS-1:0]      run_q;
	logic [LEN_BITS-1:0]      best_q;
	logic                     out_valid_q;
	logic [OUT_BITS-1:0]      window_q;
	logic [OUT_BITS-1:0]      best_out_q;
	logic                     final_q;

	logic [LEN_BITS-1:0]      run_base;
	logic [LEN_BITS-1:0]      best_base;
	logic [LEN_BITS-1:0]      run_inc;
	logic [POSITION_BITS-1:0] pos_gap;
	logic                     hit;
	logic [LEN_BITS-1:0]      run_next;
	logic [LEN_BITS-1:0]      best_next;

	always_comb begin
		run_base  = item_sos ? '0 : run_q;
		best_base = item_sos ? '0 : best_q;
		run_inc   = run_base + 1'b1;
		pos_gap   = item_pos - entry_pos;
		hit       = entry_valid && (pos_gap != '0)
			&& (CMP_BITS'(pos_gap) <= CMP_BITS'(run_base));
		if (hit) begin
			run_next  = LEN_BITS'(pos_gap);
			best_next = best_base;
		end else begin
			run_next  = run_inc;
			best_next = (run_inc > best_base) ? run_inc : best_base;
		end
	end

	// The item retires once the output register is free or being emptied.
	assign commit = item_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				run_q       <= run_next;
				best_q      <= best_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			window_q   <= OUT_BITS'(run_next);
			best_out_q <= OUT_BITS'(best_next);
			final_q    <= item_eos;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_length = window_q;
	assign best_length   = best_out_q;
	assign final_result  = final_q;

endmodule

[hw/rtl/longest_distinct_run_tracker.sv]
// Longest distinct run tracker. Each transfer on the input channel carries one
// symbol with start and end of sequence flags; each produces exactly one result
// transfer with the length of the window of distinct symbols that ends at that
// symbol, the longest such window so far in the sequence, and an echo of the end
// flag. The block sustains one symbol per cycle unless the output stalls or the
// table is being cleared; each symbol is registered in stage one and its result
// in the result register when it retires. That rate is set by the last-seen
// table, a synchronous memory with one read port and one write port: each
// symbol reads its entry in the cycle it is taken and writes it back when it
// retires from stage one, and a symbol that follows its own twin directly takes
// the position from a forwarding register instead of the stale memory word.
// After reset the table is swept clear one entry per cycle, all 2^SYMBOL_BITS
// entries (256 with the default width), while the input channel stalls.
module longest_distinct_run_tracker #(
	parameter int SYMBOL_BITS   = ldrt_pkg::SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = ldrt_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [SYMBOL_BITS-1:0]            symbol,
	input  logic                              start_of_sequence,
	input  logic                              end_of_sequence,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ldrt_pkg::LEN_OUT_BITS-1:0] window_length,
	output logic [ldrt_pkg::LEN_OUT_BITS-1:0] best_length,
	output logic                              final_result
);

	// Position counter, advanced once per accepted transfer and wrapping.
	logic [POSITION_BITS-1:0] pos_q;

	// Stage one: the item whose table word is being read.
	logic                     s1_valid_q;
	logic [SYMBOL_BITS-1:0]   sym_s1;
	logic                     sos_s1;
	logic                     eos_s1;
	logic [POSITION_BITS-1:0] pos_s1;
	logic                     fwd_s1;
	logic [POSITION_BITS-1:0] fwd_pos_s1;

	logic                     accept;
	logic                     commit;
	logic                     clearing;
	logic                     rd_valid;
	logic [POSITION_BITS-1:0] rd_pos;
	logic                     entry_valid;
	logic [POSITION_BITS-1:0] entry_pos;

	// Stall while the table is being cleared, or while stage one holds an
	// item that cannot retire this cycle.
	assign in_stall = clearing || (s1_valid_q && !commit);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q      <= pos_q + 1'b1;
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// When the retiring item writes the same entry that the new item reads in
	// the same cycle, the memory returns the old word. The forwarding register
	// remembers the retiring position so the new item sees the fresh value.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1     <= symbol;
			sos_s1     <= start_of_sequence;
			eos_s1     <= end_of_sequence;
			pos_s1     <= pos_q;
			fwd_s1     <= commit && (sym_s1 == symbol);
			fwd_pos_s1 <= pos_s1;
		end
	end

	assign entry_valid = fwd_s1 ? 1'b1 : rd_valid;
	assign entry_pos   = fwd_s1 ? fwd_pos_s1 : rd_pos;

	ldrt_table #(
		.SYMBOL_BITS  (SYMBOL_BITS),
		.POSITION_BITS(POSITION_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (symbol),
		.rd_valid(rd_valid),
		.rd_pos  (rd_pos),
		.wr_en   (commit),
		.wr_addr (sym_s1),
		.wr_pos  (pos_s1),
		.clearing(clearing)
	);

	// The update stage holds the window and best lengths and the result
	// register that parts the two channels.
	ldrt_update #(
		.SYMBOL_BITS  (SYMBOL_BITS),
		.POSITION_BITS(POSITION_BITS)
	) u_update (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (s1_valid_q),
		.item_sos     (sos_s1),
		.item_eos     (eos_s1),
		.item_pos     (pos_s1),
		.entry_valid  (entry_valid),
		.entry_pos    (entry_pos),
		.commit       (commit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_length(window_length),
		.best_length  (best_length),
		.final_result (final_result)
	);

endmodule

[tb/sv/ldrt_checker.sv]
`timescale 1ns / 1ps

module ldrt_checker #(
	parameter int SYMBOL_BITS   = ldrt_pkg::SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = ldrt_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [SYMBOL_BITS-1:0]            symbol,
	input  logic                              start_of_sequence,
	input  logic                              end_of_sequence,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [ldrt_pkg::LEN_OUT_BITS-1:0] window_length,
	input  logic [ldrt_pkg::LEN_OUT_BITS-1:0] best_length,
	input  logic                              final_result,
	output int unsigned                       fail_count,
	output int unsigned                       open_results
);

	localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;

	typedef struct packed {
		logic [ldrt_pkg::LEN_OUT_BITS-1:0] window_length;
		logic [ldrt_pkg::LEN_OUT_BITS-1:0] best_length;
		logic                              final_result;
	} run_result_t;

	// Shadow of the last-seen table and the window registers.
	bit [POSITION_BITS-1:0] seen_at [TABLE_DEPTH];
	bit                     seen_ok [TABLE_DEPTH];
	bit [POSITION_BITS-1:0] position_now = '0;
	bit [31:0]              window_now = '0;
	bit [31:0]              window_best = '0;

	run_result_t expected_runs [$];

	// Moves the shadow window on by one symbol and returns what the block must report.
	function automatic run_result_t advance_window(input logic [SYMBOL_BITS-1:0] sym,
			input logic sos, input logic eos);
		bit [POSITION_BITS-1:0] gap;
		run_result_t r;
		if (sos) begin
			window_now = '0;
			window_best = '0;
		end
		gap = position_now - seen_at[sym];
		if (seen_ok[sym] && gap != '0 && gap <= window_now) begin
			window_now = gap;
		end else begin
			window_now = window_now + 1;
			if (window_now > window_best)
				window_best = window_now;
		end
		seen_at[sym] = position_now;
		seen_ok[sym] = 1'b1;
		position_now = position_now + 1'b1;
		r.window_length = window_now[ldrt_pkg::LEN_OUT_BITS-1:0];
		r.best_length = window_best[ldrt_pkg::LEN_OUT_BITS-1:0];
		r.final_result = eos;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk) begin
		run_result_t due;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_runs.push_back(advance_window(symbol, start_of_sequence,
						end_of_sequence));
			if (out_valid && !out_stall) begin
				if (expected_runs.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					due = expected_runs.pop_front();
					if (window_length !== due.window_length)
						report_mismatch($sformatf("window_length %0d, expected %0d",
								window_length, due.window_length));
					if (best_length !== due.best_length)
						report_mismatch($sformatf("best_length %0d, expected %0d",
								best_length, due.best_length));
					if (final_result !== due.final_result)
						report_mismatch($sformatf("final_result %0b, expected %0b",
								final_result, due.final_result));
				end
			end
			open_results = expected_runs.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	// The whole run, reset sweep and drain included, takes well under a tenth of this.
	localparam int unsigned TIMEOUT_NS = 2_000_000;

	// Random items per idling phase.
	localparam int unsigned PHASE_ITEMS = 500;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [7:0]                        symbol = '0;
	logic                              start_of_sequence = 1'b0;
	logic                              end_of_sequence = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [ldrt_pkg::LEN_OUT_BITS-1:0] window_length;
	logic [ldrt_pkg::LEN_OUT_BITS-1:0] best_length;
	logic                              final_result;

	int unsigned fail_count;
	int unsigned open_results;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned send_idle_pct = 22;
	int unsigned stall_pct = 84;
	int unsigned items_sent = 0;

	always #5 clk = ~clk;

	longest_distinct_run_tracker dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.symbol            (symbol),
		.start_of_sequence (start_of_sequence),
		.end_of_sequence   (end_of_sequence),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.window_length     (window_length),
		.best_length       (best_length),
		.final_result      (final_result)
	);

	ldrt_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.symbol            (symbol),
		.start_of_sequence (start_of_sequence),
		.end_of_sequence   (end_of_sequence),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.window_length     (window_length),
		.best_length       (best_length),
		.final_result      (final_result),
		.fail_count        (fail_count),
		.open_results      (open_results)
	);

	// The receiver stalls on its own schedule; it never looks at the result valid.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Offers one symbol and returns at the edge where the transfer takes place. The
	// valid stays high afterwards, so back-to-back transfers need no extra edge; it is
	// only lowered when the next call decides to leave a gap.
	task automatic send_symbol(input logic [7:0] sym, input logic sos, input logic eos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		start_of_sequence <= sos;
		end_of_sequence <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent = items_sent + 1;
	endtask

	// A sequence holding every symbol once, in shuffled order, drives both lengths
	// up to the full table size of 256.
	task automatic send_permutation();
		logic [7:0] order [256];
		logic [7:0] swap;
		int         j;
		for (int i = 0; i < 256; i++)
			order[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < 256; i++)
			send_symbol(order[i], i == 0, i == 255);
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		logic [7:0]  alpha_mask;
		logic [7:0]  base;
		int unsigned phase_end;

		// Reset is held low first. Afterwards the block sweeps its table and
		// stalls the input, which the handshake in send_symbol simply waits out.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The very first symbols hit never-written table entries,
		// which must read as not seen.
		send_symbol(8'd0, 1'b1, 1'b0);
		send_symbol(8'd255, 1'b0, 1'b0);
		// A repeat two back shrinks the window to two.
		send_symbol(8'd0, 1'b0, 1'b0);
		// Back-to-back twins exercise the forwarding path: the window drops to one.
		send_symbol(8'd0, 1'b0, 1'b0);
		send_symbol(8'd0, 1'b0, 1'b0);
		send_symbol(8'd7, 1'b0, 1'b0);
		send_symbol(8'd8, 1'b0, 1'b0);
		send_symbol(8'd9, 1'b0, 1'b0);
		// Window is 0,7,8,9; the earlier 7 lies three back, inside it.
		send_symbol(8'd7, 1'b0, 1'b0);
		send_symbol(8'd8, 1'b0, 1'b1);
		// New sequence: the table keeps entries of the old one, but they lie behind
		// the emptied window and must not count as repeats.
		send_symbol(8'd255, 1'b1, 1'b0);
		send_symbol(8'd9, 1'b0, 1'b0);
		send_symbol(8'd7, 1'b0, 1'b0);
		send_symbol(8'd0, 1'b0, 1'b0);
		// Repeat at a distance exactly equal to the window length.
		send_symbol(8'd255, 1'b0, 1'b1);
		// A one-symbol sequence with both flags on the same transfer.
		send_symbol(8'd170, 1'b1, 1'b1);
		// A sequence started without the previous one having been closed.
		send_symbol(8'd85, 1'b1, 1'b0);
		send_symbol(8'd170, 1'b0, 1'b0);
		send_symbol(8'd85, 1'b0, 1'b0);
		send_symbol(8'd1, 1'b1, 1'b0);
		send_symbol(8'd85, 1'b0, 1'b1);

		// Random part in three idling phases: slow receiver, slow sender, no idling.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					stall_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					stall_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			if (phase == 2)
				send_permutation();
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					send_permutation();
				end else if (pick < 12) begin
					// Noise: flags set at random, sequences broken or never closed.
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++)
						send_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
								1'($urandom_range(0, 1)));
				end else begin
					// Well-formed sequence over an alphabet of random size and offset,
					// so that repeats come at every distance from one to the window.
					len = $urandom_range(1, 48);
					case ($urandom_range(0, 3))
						0: alpha_mask = 8'h01;
						1: alpha_mask = 8'h07;
						2: alpha_mask = 8'h1f;
						default: alpha_mask = 8'hff;
					endcase
					base = 8'($urandom_range(0, 255));
					for (int i = 0; i < len; i++)
						send_symbol(base + (8'($urandom) & alpha_mask), i == 0, i == len - 1);
				end
			end
		end

		// The last transfer has just happened; drop the valid in that same step.
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		// Leave room for any stray result.
		repeat (8) @(posedge clk);

		if (fail_count == 0 && open_results == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[longest_distinct_run_tracker.f]
hw/rtl/ldrt_pkg.sv
hw/rtl/ldrt_table.sv
hw/rtl/ldrt_update.sv
hw/rtl/longest_distinct_run_tracker.sv
tb/sv/ldrt_checker.sv
tb/sv/tb_top.sv
